[design/gcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared definitions for the great-circle distance block
// Pipeline depths, CORDIC arctangent table, unit codes, scale factors and the
// types that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Register stages in the front end and in the back end.
    localparam int FRONT_LAT = 6;
    localparam int BACK_LAT  = 2 * CORDIC_STEPS + 43;
    localparam int TOTAL_LAT = FRONT_LAT + 1 + BACK_LAT;

    // Arctangent of 2^-i in phase units, where 2^32 is one full turn.
    localparam logic [31:0] ATAN_PHASE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

    // Distance unit codes.
    localparam logic [1:0] UNIT_MILES    = 2'd0;
    localparam logic [1:0] UNIT_METERS   = 2'd1;
    localparam logic [1:0] UNIT_NAUTICAL = 2'd2;
    localparam logic [1:0] UNIT_RESET    = UNIT_METERS;

    // Angle-to-distance factors, applied as (z * M + 2^30) >> 31.
    localparam logic [32:0] SCALE_MILES    = 33'd3183667;
    localparam logic [32:0] SCALE_METERS   = 33'd5123615706;
    localparam logic [32:0] SCALE_NAUTICAL = 33'd2764697;

    localparam logic [32:0] PATH_MAX = 33'h1_FFFF_FFFF;

    // Multiplicative inverse modulo 2^32 by Newton iteration.
    function automatic logic [31:0] inv_mod32(input logic [31:0] d);
        logic [31:0] x;
        x = d;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - d * x);
        end
        return x;
    endfunction

    localparam logic [31:0] INV45 = inv_mod32(32'd45);

    typedef struct packed {
        logic [31:0] lat1_ph;
        logic [31:0] lat2_ph;
        logic [31:0] dlon_ph;
        logic        same;
    } t_item;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [QPTR_W:0] count;
    } t_qstat;

endpackage

[design/gcd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_front: input conversion and classification
// Turns the four Q8.23 degree fields into 32-bit phases, forms the longitude
// difference and flags identical points. Six register stages.
// ----------------------------------------------------------------------------
module gcd_front import gcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_first_latitude,
    input  logic [31:0] i_first_longitude,
    input  logic [31:0] i_second_latitude,
    input  logic [31:0] i_second_longitude,
    output logic        o_valid,
    output t_item       o_item
);

    localparam int LANES = 4;
    localparam logic [44:0] PHASE_BIAS = 45'd45 << 38;

    logic [31:0] w_raw   [LANES];
    logic [13:0] w_sum   [LANES];
    logic [12:0] w_fold  [LANES];
    logic [7:0]  w_quo   [LANES];
    logic [12:0] w_rem0  [LANES];
    logic [6:0]  w_rem   [LANES];

    logic [44:0] r_n     [LANES];
    logic [12:0] r_a     [LANES];
    logic [31:0] r_lo_b  [LANES];
    logic [23:0] r_prod  [LANES];
    logic [12:0] r_a_c   [LANES];
    logic [31:0] r_lo_c  [LANES];
    logic [31:0] r_low   [LANES];
    logic [31:0] r_ph    [LANES];

    logic [4:0]  r_v;
    logic [4:0]  r_same;
    logic        r_valid;
    t_item       r_item;

    assign w_raw[0] = i_first_latitude;
    assign w_raw[1] = i_first_longitude;
    assign w_raw[2] = i_second_latitude;
    assign w_raw[3] = i_second_longitude;

    // The phase is floor((raw*64 + 22) / 45) mod 2^32. Since 2^12 = 1 mod 45,
    // the remainder comes from folding 12-bit chunks; the exact quotient then
    // follows from a multiply by the inverse of 45 modulo 2^32.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_sum[l]  = 14'(r_n[l][11:0]) + 14'(r_n[l][23:12])
                      + 14'(r_n[l][35:24]) + 14'(r_n[l][44:36]);
            w_fold[l] = 13'(w_sum[l][11:0]) + 13'(w_sum[l][13:12]);
            w_quo[l]  = r_prod[l][23:16];
            w_rem0[l] = r_a_c[l] - 13'(w_quo[l]) * 13'd45;
            w_rem[l]  = (w_rem0[l] >= 13'd45) ? 7'(w_rem0[l] - 13'd45) : 7'(w_rem0[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_n[l]    <= ({{13{w_raw[l][31]}}, w_raw[l]} << 6) + 45'd22 + PHASE_BIAS;
            r_a[l]    <= w_fold[l];
            r_lo_b[l] <= r_n[l][31:0];
            r_prod[l] <= 24'(r_a[l]) * 24'd1456;
            r_a_c[l]  <= r_a[l];
            r_lo_c[l] <= r_lo_b[l];
            r_low[l]  <= r_lo_c[l] - 32'(w_rem[l]);
            r_ph[l]   <= r_low[l] * INV45;
        end
        r_same <= {r_same[3:0], (i_first_latitude == i_second_latitude) &&
                                (i_first_longitude == i_second_longitude)};
        r_item.lat1_ph <= r_ph[0];
        r_item.lat2_ph <= r_ph[2];
        r_item.dlon_ph <= r_ph[1] - r_ph[3];
        r_item.same    <= r_same[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[3:0], i_valid};
            r_valid <= r_v[4];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/gcd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_queue: short queue between front end and back end
// Holds classified items until the back end takes them; the back end pops
// whenever an entry is present.
// ----------------------------------------------------------------------------
module gcd_queue import gcd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    output logic   o_pop,
    output t_item  o_item,
    output t_qstat o_stat
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              w_pop;

    assign w_pop   = (r_count != '0);
    assign n_count = r_count + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_pop        = w_pop;
    assign o_item       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_stat.empty = !w_pop;
    assign o_stat.count = r_count;

endmodule

[design/gcd_rot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_rot: pipelined rotation CORDIC
// Gives sine and cosine in Q2.30 of a 32-bit phase, one stage per iteration.
// ----------------------------------------------------------------------------
module gcd_rot import gcd_pkg::*; (
    input  logic               i_clk,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    logic [31:0]        w_turn;
    logic               w_flip;
    logic [31:0]        w_ph;

    logic signed [33:0] r_x    [CORDIC_STEPS + 1];
    logic signed [33:0] r_y    [CORDIC_STEPS + 1];
    logic signed [33:0] r_z    [CORDIC_STEPS + 1];
    logic               r_flip [CORDIC_STEPS + 1];
    logic signed [33:0] r_sin;
    logic signed [33:0] r_cos;

    // Phases in the left half-plane are turned by half a turn first and the
    // result is negated at the end.
    assign w_turn = i_phase + 32'h4000_0000;
    assign w_flip = w_turn[31];
    assign w_ph   = w_flip ? i_phase + 32'h8000_0000 : i_phase;

    always_ff @(posedge i_clk) begin
        r_x[0]    <= {2'b00, CORDIC_GAIN};
        r_y[0]    <= '0;
        r_z[0]    <= {{2{w_ph[31]}}, w_ph};
        r_flip[0] <= w_flip;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [33:0] ATAN_K = {2'b00, ATAN_PHASE[k]};
        always_ff @(posedge i_clk) begin
            if (r_z[k] >= 0) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ATAN_K;
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ATAN_K;
            end
            r_flip[k+1] <= r_flip[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sin <= r_flip[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        r_cos <= r_flip[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    end

    assign o_sin = r_sin[31:0];
    assign o_cos = r_cos[31:0];

endmodule

[design/gcd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_back: law-of-cosines datapath
// Sine and cosine, the cosine sum, square root, vectoring CORDIC for the
// arc cosine and the unit scaling, fully pipelined.
// ----------------------------------------------------------------------------
module gcd_back import gcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [1:0]  i_unit,
    output logic        o_valid,
    output logic [32:0] o_path_length
);

    localparam int SQ_STEPS = 32;

    // Trig
    logic signed [31:0] w_s1, w_c1, w_s2, w_c2, w_cd;

    // Cosine sum
    logic signed [63:0] r_p1, r_p2;
    logic signed [31:0] r_cd;
    logic signed [33:0] r_t1;
    logic signed [63:0] r_p3;
    logic signed [34:0] w_sum;
    logic signed [31:0] r_arg;

    // Square root of 2^60 - c*c
    logic [60:0]        r_csq;
    logic signed [31:0] r_c0;
    logic [63:0]        r_sn [SQ_STEPS + 1];
    logic [63:0]        r_sr [SQ_STEPS + 1];
    logic signed [31:0] r_sc [SQ_STEPS + 1];

    // Vectoring CORDIC
    logic signed [33:0] w_s;
    logic signed [33:0] w_c;
    logic signed [33:0] r_vx [CORDIC_STEPS + 1];
    logic signed [33:0] r_vy [CORDIC_STEPS + 1];
    logic signed [33:0] r_vz [CORDIC_STEPS + 1];
    logic [31:0]        r_ang;

    // Scaling
    logic [32:0]        w_scale;
    logic [48:0]        r_pl;
    logic [47:0]        r_ph;
    logic [65:0]        w_acc;
    logic [34:0]        w_dist;
    logic [32:0]        r_out;

    logic [BACK_LAT-1:0] r_vld;
    logic [BACK_LAT-1:0] r_same;

    gcd_rot u_rot_lat1 (
        .i_clk   (i_clk),
        .i_phase (i_item.lat1_ph),
        .o_sin   (w_s1),
        .o_cos   (w_c1)
    );

    gcd_rot u_rot_lat2 (
        .i_clk   (i_clk),
        .i_phase (i_item.lat2_ph),
        .o_sin   (w_s2),
        .o_cos   (w_c2)
    );

    gcd_rot u_rot_dlon (
        .i_clk   (i_clk),
        .i_phase (i_item.dlon_ph),
        .o_sin   (),
        .o_cos   (w_cd)
    );

    assign w_sum = 35'(r_t1) + 35'(r_p3 >>> 30);

    always_ff @(posedge i_clk) begin
        r_p1 <= 64'(w_s1) * 64'(w_s2);
        r_p2 <= 64'(w_c1) * 64'(w_c2);
        r_cd <= w_cd;
        r_t1 <= 34'(r_p1 >>> 30);
        r_p3 <= 64'(signed'(r_p2[61:30])) * 64'(r_cd);
        if (w_sum > 35'sh4000_0000) begin
            r_arg <= 32'sh4000_0000;
        end else if (w_sum < -35'sh4000_0000) begin
            r_arg <= -32'sh4000_0000;
        end else begin
            r_arg <= w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_csq   <= 61'(64'(r_arg) * 64'(r_arg));
        r_c0    <= r_arg;
        r_sn[0] <= 64'(61'h1000_0000_0000_0000 - r_csq);
        r_sr[0] <= '0;
        r_sc[0] <= r_c0;
    end

    // One result bit per stage, trial subtraction of r + b.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT_K = 64'd1 << (62 - 2 * k);
        always_ff @(posedge i_clk) begin
            if (r_sn[k] >= r_sr[k] + BIT_K) begin
                r_sn[k+1] <= r_sn[k] - (r_sr[k] + BIT_K);
                r_sr[k+1] <= (r_sr[k] >> 1) + BIT_K;
            end else begin
                r_sn[k+1] <= r_sn[k];
                r_sr[k+1] <= r_sr[k] >> 1;
            end
            r_sc[k+1] <= r_sc[k];
        end
    end

    assign w_s = {2'b00, r_sr[SQ_STEPS][31:0]};
    assign w_c = 34'(r_sc[SQ_STEPS]);

    // A negative cosine starts from the vector turned back by a quarter turn.
    always_ff @(posedge i_clk) begin
        if (w_c < 0) begin
            r_vx[0] <= w_s;
            r_vy[0] <= -w_c;
            r_vz[0] <= 34'sh4000_0000;
        end else begin
            r_vx[0] <= w_c;
            r_vy[0] <= w_s;
            r_vz[0] <= '0;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        localparam logic signed [33:0] ATAN_K = {2'b00, ATAN_PHASE[k]};
        always_ff @(posedge i_clk) begin
            if (r_vy[k] > 0) begin
                r_vx[k+1] <= r_vx[k] + (r_vy[k] >>> k);
                r_vy[k+1] <= r_vy[k] - (r_vx[k] >>> k);
                r_vz[k+1] <= r_vz[k] + ATAN_K;
            end else begin
                r_vx[k+1] <= r_vx[k] - (r_vy[k] >>> k);
                r_vy[k+1] <= r_vy[k] + (r_vx[k] >>> k);
                r_vz[k+1] <= r_vz[k] - ATAN_K;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vz[CORDIC_STEPS] < 0) begin
            r_ang <= '0;
        end else if (r_vz[CORDIC_STEPS] > 34'sh8000_0000) begin
            r_ang <= 32'h8000_0000;
        end else begin
            r_ang <= r_vz[CORDIC_STEPS][31:0];
        end
    end

    always_comb begin
        case (i_unit)
            UNIT_MILES:    w_scale = SCALE_MILES;
            UNIT_METERS:   w_scale = SCALE_METERS;
            UNIT_NAUTICAL: w_scale = SCALE_NAUTICAL;
            default:       w_scale = SCALE_MILES;
        endcase
    end

    assign w_acc  = (66'(r_ph) << 17) + 66'(r_pl) + (66'd1 << 30);
    assign w_dist = w_acc[65:31];

    always_ff @(posedge i_clk) begin
        r_pl  <= 49'(r_ang) * 49'(w_scale[16:0]);
        r_ph  <= 48'(r_ang) * 48'(w_scale[32:17]);
        r_out <= (w_dist > 35'(PATH_MAX)) ? PATH_MAX : w_dist[32:0];
    end

    always_ff @(posedge i_clk) begin
        r_same <= {r_same[BACK_LAT-2:0], i_item.same};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[BACK_LAT-2:0], i_valid};
        end
    end

    assign o_valid       = r_vld[BACK_LAT-1];
    assign o_path_length = r_same[BACK_LAT-1] ? '0 : r_out;

endmodule

[design/great_circle_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance: spherical law of cosines distance
// Distance between two latitude/longitude points in miles, meters or nautical
// miles, pipelined at one point pair per clock.
// ----------------------------------------------------------------------------
// Usage
//   Drive the four Q8.23 degree fields and raise start; the transaction is
//   taken at a clock edge where start is high and busy is low. Back-to-back
//   transactions may be issued on every cycle.
//   Each result appears on o_path_length (unsigned, 8 fraction bits) for one
//   cycle with o_valid high, after the transaction has passed the front end,
//   the queue and the back end. Results come out in order.
//   Latency is set by the two CORDIC pipelines and the bit-per-stage square
//   root; throughput is one transaction per cycle.
//   The receiver cannot stall: results are not held, and the back end drains
//   the queue every cycle, so busy stays low in operation.
//   i_cfg_we with i_cfg_wdata writes the distance unit (0 statute miles,
//   1 meters, 2 nautical miles, 3 as miles); write it only when idle.
//   Synchronous reset clears all pending work and sets the unit to meters.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_first_latitude,
    input  logic [31:0] i_first_longitude,
    input  logic [31:0] i_second_latitude,
    input  logic [31:0] i_second_longitude,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [32:0] o_path_length
);

    logic [1:0] r_distance_unit;
    logic       w_accept;
    logic       w_front_valid;
    t_item      w_front_item;
    logic       w_pop;
    t_item      w_queue_item;
    t_qstat     w_qstat;

    assign busy     = w_qstat.full;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_unit <= UNIT_RESET;
        end else if (i_cfg_we) begin
            r_distance_unit <= i_cfg_wdata;
        end
    end

    gcd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_accept),
        .i_first_latitude   (i_first_latitude),
        .i_first_longitude  (i_first_longitude),
        .i_second_latitude  (i_second_latitude),
        .i_second_longitude (i_second_longitude),
        .o_valid            (w_front_valid),
        .o_item             (w_front_item)
    );

    gcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_item  (w_front_item),
        .o_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_stat  (w_qstat)
    );

    gcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_pop),
        .i_item        (w_queue_item),
        .i_unit        (r_distance_unit),
        .o_valid       (o_valid),
        .o_path_length (o_path_length)
    );

`ifndef SYNTHESIS
    // The queue is never pushed while full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_front_valid && w_qstat.full))
        else $error("queue overflow");

    // The back end drains every cycle, so at most one entry waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= (QPTR_W + 1)'(1))
        else $error("queue backlog");

    // Every result traces back to a transaction a fixed latency earlier.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, TOTAL_LAT))
        else $error("result without transaction");
`endif

endmodule

[tb/sv/great_circle_distance_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_test: self-checking bench for the distance block
// A table of point pairs runs first, then random point pairs under every
// distance unit. Each path length is compared with the length given in the
// table or with a bit-exact fixed-point model kept inside the bench.
// ----------------------------------------------------------------------------
module great_circle_distance_test;
    import gcd_pkg::*;

    localparam logic [1:0] UNIT_ALT_MILES = 2'd3;
    localparam int         RAND_PER_UNIT  = 140;
    localparam int         STALL_LIMIT    = 4000;
    localparam longint     DEG            = 64'sd8388608;

    typedef struct {
        logic [31:0] lat1, lon1, lat2, lon2;
        bit          typed;
        logic [32:0] length;
    } t_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_first_latitude = '0;
    logic [31:0] i_first_longitude = '0;
    logic [31:0] i_second_latitude = '0;
    logic [31:0] i_second_longitude = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        o_valid;
    logic [32:0] o_path_length;

    logic [1:0]  unit_now = UNIT_RESET;
    logic [32:0] pending_lengths[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          took_item;

    great_circle_distance i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_first_latitude   (i_first_latitude),
        .i_first_longitude  (i_first_longitude),
        .i_second_latitude  (i_second_latitude),
        .i_second_longitude (i_second_longitude),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_path_length      (o_path_length)
    );

    always #6 i_clk = ~i_clk;

    // Q8.23 degrees to phase, 2^32 per turn, rounded to nearest.
    function automatic logic [31:0] degrees_to_phase(input logic [31:0] raw);
        longint      s;
        logic [63:0] t;
        logic [63:0] q;
        s = longint'($signed(raw));
        t = s * 64 + 45 * (64'sd1 <<< 38);
        q = (t + 64'd22) / 64'd45;
        return q[31:0];
    endfunction

    function automatic void sine_cosine(input logic [31:0] p, output longint sn,
                                        output longint cs);
        logic        flip;
        logic [31:0] q;
        logic [31:0] probe;
        longint      x, y, z, dx, dy, a;
        probe = p + 32'h4000_0000;
        flip = probe[31];
        q = flip ? p + 32'h8000_0000 : p;
        z = longint'($signed(q));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            a = longint'(ATAN_PHASE[i]);
            if (z >= 0) begin
                x -= dx; y += dy; z -= a;
            end else begin
                x += dx; y -= dy; z += a;
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Central angle in phase units from its cosine in Q2.30.
    function automatic longint central_angle(input longint c);
        logic [63:0] rem;
        longint      x, y, z, s, dx, dy, a;
        rem = (64'd1 << 60) - c * c;
        s = longint'(int_sqrt(rem));
        x = c; y = s; z = 0;
        if (x < 0) begin
            x = s; y = -c; z = 64'sh4000_0000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            a = longint'(ATAN_PHASE[i]);
            if (y > 0) begin
                x += dx; y -= dy; z += a;
            end else begin
                x -= dx; y += dy; z -= a;
            end
        end
        if (z < 0) z = 0;
        if (z > 64'sh8000_0000) z = 64'sh8000_0000;
        return z;
    endfunction

    function automatic logic [32:0] predict_length(input t_pair pt, input logic [1:0] unit);
        longint      s1, c1, s2, c2, sd, cd, arg;
        logic [63:0] m, d;
        if (pt.lat1 == pt.lat2 && pt.lon1 == pt.lon2) return '0;
        sine_cosine(degrees_to_phase(pt.lat1), s1, c1);
        sine_cosine(degrees_to_phase(pt.lat2), s2, c2);
        sine_cosine(degrees_to_phase(pt.lon1) - degrees_to_phase(pt.lon2), sd, cd);
        arg = ((s1 * s2) >>> 30) + ((((c1 * c2) >>> 30) * cd) >>> 30);
        if (arg > 64'sh4000_0000) arg = 64'sh4000_0000;
        if (arg < -64'sh4000_0000) arg = -64'sh4000_0000;
        case (unit)
            UNIT_METERS:   m = 64'(SCALE_METERS);
            UNIT_NAUTICAL: m = 64'(SCALE_NAUTICAL);
            default:       m = 64'(SCALE_MILES);
        endcase
        d = (64'(central_angle(arg)) * m + (64'd1 << 30)) >> 31;
        if (d > 64'(PATH_MAX)) d = 64'(PATH_MAX);
        return d[32:0];
    endfunction

    task automatic report(input string what, input logic [32:0] want, input logic [32:0] got);
        $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        errors++;
    endtask

    // Sends one transaction and leaves start high; the caller lowers it.
    task automatic send_pair(input t_pair pt);
        i_first_latitude   <= pt.lat1;
        i_first_longitude  <= pt.lon1;
        i_second_latitude  <= pt.lat2;
        i_second_longitude <= pt.lon2;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_lengths.push_back(pt.typed ? pt.length : predict_length(pt, unit_now));
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_unit(input logic [1:0] unit);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_lengths.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= unit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unit_now = unit;
    endtask

    function automatic logic [31:0] span(input longint limit);
        return 32'($urandom_range(0, 32'(2 * limit)) - limit);
    endfunction

    function automatic t_pair random_pair();
        t_pair pt;
        pt.typed = 1'b0;
        pt.length = '0;
        pt.lat1 = span(90 * DEG);
        pt.lon1 = span(180 * DEG);
        pt.lat2 = span(90 * DEG);
        pt.lon2 = span(180 * DEG);
        case ($urandom_range(0, 9))
            6: begin
                pt.lat1 = $urandom; pt.lon1 = $urandom;
                pt.lat2 = $urandom; pt.lon2 = $urandom;
            end
            7: begin
                pt.lat2 = pt.lat1; pt.lon2 = pt.lon1;
            end
            8: begin
                pt.lat2 = pt.lat1 + span(1 << 16);
                pt.lon2 = pt.lon1 + span(1 << 16);
            end
            9: begin
                pt.lat2 = -pt.lat1;
                pt.lon2 = pt.lon1 + 32'(180 * DEG);
            end
            default: ;
        endcase
        return pt;
    endfunction

    // Results cannot be held off, so every strobe is checked on the spot.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_lengths.size() == 0) begin
                report("unexpected result", '0, o_path_length);
            end else if (pending_lengths[0] !== o_path_length) begin
                report("path length", pending_lengths[0], o_path_length);
                void'(pending_lengths.pop_front());
            end else begin
                void'(pending_lengths.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        took_item = start && !busy;
        if (!i_rst_n || took_item || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("great_circle_distance regression: fail");
            $finish;
        end
    end

    initial begin
        t_pair       directed[] = '{
            '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 33'h0},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 33'h0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 33'h0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 33'h0},
            '{32'h0, 32'h0, 32'h0, 32'(180 * DEG), 1'b0, 33'h0},
            '{32'(90 * DEG), 32'h0, 32'(-90 * DEG), 32'h0, 1'b0, 33'h0},
            '{32'(90 * DEG), 32'h0, 32'(90 * DEG), 32'(180 * DEG), 1'b0, 33'h0},
            '{32'h0, 32'h0, 32'h0, 32'h1, 1'b0, 33'h0},
            '{32'h1, 32'h0, 32'h0, 32'h0, 1'b0, 33'h0},
            '{32'h0, 32'h0, 32'h0, 32'(360 * DEG), 1'b0, 33'h0},
            '{32'(200 * DEG), 32'(-250 * DEG), 32'(-20 * DEG), 32'(110 * DEG), 1'b0, 33'h0},
            '{32'(45 * DEG), 32'(30 * DEG), 32'(-45 * DEG), 32'(-150 * DEG), 1'b0, 33'h0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 33'h0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 33'h0}
        };
        logic [1:0]  unit_plan[] = '{UNIT_MILES, UNIT_NAUTICAL, UNIT_ALT_MILES,
                                     UNIT_METERS, UNIT_MILES};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_pair(directed[k]);
            pause_sender();
        end

        foreach (unit_plan[u]) begin
            write_unit(unit_plan[u]);
            for (int n = 0; n < RAND_PER_UNIT; n++) begin
                send_pair(random_pair());
                pause_sender();
            end
        end

        start <= 1'b0;
        while (pending_lengths.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("great_circle_distance regression: pass");
        end else begin
            $display("great_circle_distance regression: fail");
        end
        $finish;
    end

endmodule
